// ===== sv/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg: shared constants for the double-ended queue
// Ring geometry, beat layout, operation codes and status codes.
// ----------------------------------------------------------------------------
package deq_pkg;

  // Ring geometry
  localparam int DEPTH  = 16;
  localparam int ITEM_W = 32;
  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = PTR_W + 1;

  // Field widths
  localparam int FUNC_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // Beat widths, rounded up to whole bytes
  localparam int IN_BITS     = FUNC_W + VALUE_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = 3 * VALUE_W + STATUS_W + COUNT_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Operation codes
  localparam logic [FUNC_W-1:0] OP_NONE  = 3'd0;
  localparam logic [FUNC_W-1:0] OP_ADD_F = 3'd1;
  localparam logic [FUNC_W-1:0] OP_ADD_B = 3'd2;
  localparam logic [FUNC_W-1:0] OP_REM_F = 3'd3;
  localparam logic [FUNC_W-1:0] OP_REM_B = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage

// ===== sv/double_ended_queue.sv =====
// A new beat is taken only once the previous result is loaded into the output
//   register, after the two back-to-back reads of the slot memory (removed slot,
//   then new front and back slots). The output register holds a finished
//   result while the next beat is taken.
// Reset (rst_n low, synchronous) empties the queue and clears the front
//   pointer; slot memory contents are left as they are, with no clearing pass.
// ----------------------------------------------------------------------------
// double_ended_queue: ring-buffer deque of item handles
// Add or remove at either end; each beat returns the removed item, a status,
// the count and the first and last items held afterwards.
// ----------------------------------------------------------------------------
module double_ended_queue (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // func[2:0], item_value[34:3], zero fill above
  input  logic [deq_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // removed_item[31:0], status[33:32], item_count[38:34],
  // first_item[70:39], last_item[102:71], zero fill above
  output logic [deq_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import deq_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_FETCH = 2'd2;
  localparam logic [1:0] S_LOAD  = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [FUNC_W-1:0]   op_r;
  logic [ITEM_W-1:0]   val_r;
  logic [PTR_W-1:0]    front_r, front_nxt;
  logic [CNT_W-1:0]    occ_r, occ_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic                rem_ok_r, rem_ok_nxt;
  logic [VALUE_W-1:0]  removed_r;

  logic [ITEM_W-1:0]   mem [DEPTH];
  logic [ITEM_W-1:0]   rd_a_r, rd_b_r;
  logic                wr_en, rd_en;
  logic [PTR_W-1:0]    wr_addr, rd_a_addr;

  logic                out_tvalid_r;
  logic [VALUE_W-1:0]  o_removed_r, o_first_r, o_last_r;
  logic [STATUS_W-1:0] o_status_r;
  logic [COUNT_W-1:0]  o_count_r;

  logic                is_add, is_rem, full, empty, load_out;
  logic [SUM_W-1:0]    tail_sum, back_sum;
  logic [PTR_W-1:0]    tail_idx, back_idx, front_inc, front_dec;

  // Ring index arithmetic
  always_comb begin
    tail_sum  = SUM_W'(front_r) + SUM_W'(occ_r);
    back_sum  = tail_sum - SUM_W'(1);
    tail_idx  = (tail_sum >= SUM_W'(DEPTH)) ? PTR_W'(tail_sum - SUM_W'(DEPTH))
                                            : PTR_W'(tail_sum);
    back_idx  = (back_sum >= SUM_W'(DEPTH)) ? PTR_W'(back_sum - SUM_W'(DEPTH))
                                            : PTR_W'(back_sum);
    front_inc = (front_r == PTR_W'(DEPTH - 1)) ? '0 : front_r + PTR_W'(1);
    front_dec = (front_r == '0) ? PTR_W'(DEPTH - 1) : front_r - PTR_W'(1);
  end

  assign is_add   = (op_r == OP_ADD_F) || (op_r == OP_ADD_B);
  assign is_rem   = (op_r == OP_REM_F) || (op_r == OP_REM_B);
  assign full     = (occ_r == CNT_W'(DEPTH));
  assign empty    = (occ_r == '0);
  assign load_out = (state_r == S_LOAD) && (!out_tvalid_r || out_tready);

  // Sequencer and pointer update
  always_comb begin
    state_nxt  = state_r;
    front_nxt  = front_r;
    occ_nxt    = occ_r;
    status_nxt = status_r;
    rem_ok_nxt = rem_ok_r;
    wr_en      = 1'b0;
    wr_addr    = tail_idx;
    rd_en      = 1'b0;
    rd_a_addr  = front_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        status_nxt = ST_OK;
        rem_ok_nxt = 1'b0;
        rd_en      = 1'b1;
        rd_a_addr  = (op_r == OP_REM_F) ? front_r : back_idx;
        if (is_add) begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            wr_en   = 1'b1;
            occ_nxt = occ_r + CNT_W'(1);
            if (op_r == OP_ADD_F) begin
              wr_addr   = front_dec;
              front_nxt = front_dec;
            end
          end
        end else if (is_rem) begin
          if (empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            rem_ok_nxt = 1'b1;
            occ_nxt    = occ_r - CNT_W'(1);
            if (op_r == OP_REM_F) front_nxt = front_inc;
          end
        end
        state_nxt = S_FETCH;
      end
      S_FETCH: begin
        rd_en     = 1'b1;
        rd_a_addr = front_r;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (load_out) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_tready = (state_r == S_IDLE);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      front_r      <= '0;
      occ_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      front_r <= front_nxt;
      occ_r   <= occ_nxt;
      if (load_out) out_tvalid_r <= 1'b1;
      else if (out_tready) out_tvalid_r <= 1'b0;
    end
  end

  // Beat capture and status
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r  <= in_tdata[FUNC_W-1:0];
      val_r <= ITEM_W'(in_tdata[FUNC_W +: VALUE_W]);
    end
    status_r <= status_nxt;
    rem_ok_r <= rem_ok_nxt;
    // removed slot data lands in rd_a_r during FETCH
    if (state_r == S_FETCH) removed_r <= rem_ok_r ? VALUE_W'(rd_a_r) : '0;
  end

  // Slot memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= val_r;
    if (rd_en) begin
      rd_a_r <= mem[rd_a_addr];
      rd_b_r <= mem[back_idx];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (load_out) begin
      o_removed_r <= removed_r;
      o_status_r  <= status_r;
      o_count_r   <= COUNT_W'(occ_r);
      o_first_r   <= empty ? '0 : VALUE_W'(rd_a_r);
      o_last_r    <= empty ? '0 : VALUE_W'(rd_b_r);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_TDATA_W'({o_last_r, o_first_r, o_count_r, o_status_r,
                                    o_removed_r});

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CNT_W'(DEPTH))
    else $error("occupancy above ring depth");

  a_front_bound: assert property (@(posedge clk) disable iff (!rst_n)
    front_r <= PTR_W'(DEPTH - 1))
    else $error("front pointer outside ring");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && o_status_r == ST_FULL) |-> (o_count_r == COUNT_W'(DEPTH)))
    else $error("full status with ring not full");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && o_status_r == ST_EMPTY) |-> (o_count_r == '0))
    else $error("empty status with items held");

  a_state_only_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_EXEC) |=> (occ_r == $past(occ_r)))
    else $error("count changed outside execute step");
`endif

endmodule

// ===== dv/double_ended_queue_tb.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue_tb: self-checking bench for the ring-buffer deque
// Sends add, remove and no-op beats with random gaps and back-pressure, runs
// a behavioral copy of the ring alongside the block, and compares every
// result beat field by field in the order the operations were accepted.
// ----------------------------------------------------------------------------
module double_ended_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import deq_pkg::*;

  // Result beat layout, lowest field first
  localparam int OFS_STATUS = VALUE_W;
  localparam int OFS_COUNT  = OFS_STATUS + STATUS_W;
  localparam int OFS_FIRST  = OFS_COUNT + COUNT_W;
  localparam int OFS_LAST   = OFS_FIRST + VALUE_W;

  typedef struct packed {
    logic [VALUE_W-1:0]  removed;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
    logic [VALUE_W-1:0]  first;
    logic [VALUE_W-1:0]  last;
  } deq_result_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // Shadow copy of the ring
  logic [VALUE_W-1:0] ring_slots [DEPTH];
  int                 ring_front;
  int                 ring_count;

  deq_result_t pending_results [$];
  int          error_cnt;
  bit          tx_gaps_on;
  bit          rx_stalls_on;

  double_ended_queue dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Apply one operation to the shadow ring and return the expected beat
  function automatic deq_result_t apply_deq_op(logic [FUNC_W-1:0] func,
                                               logic [VALUE_W-1:0] value);
    deq_result_t r;
    int          idx;
    r = '0;
    r.status = ST_OK;
    case (func)
      OP_ADD_F, OP_ADD_B: begin
        if (ring_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          if (func == OP_ADD_F) begin
            ring_front = (ring_front == 0) ? DEPTH - 1 : ring_front - 1;
            idx = ring_front;
          end else begin
            idx = (ring_front + ring_count) % DEPTH;
          end
          ring_slots[idx] = value;
          ring_count++;
        end
      end
      OP_REM_F, OP_REM_B: begin
        if (ring_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          if (func == OP_REM_F) begin
            r.removed = ring_slots[ring_front];
            ring_front = (ring_front + 1) % DEPTH;
          end else begin
            r.removed = ring_slots[(ring_front + ring_count - 1) % DEPTH];
          end
          ring_count--;
        end
      end
      default: ; // unused codes behave as no-op
    endcase
    r.count = ring_count[COUNT_W-1:0];
    if (ring_count != 0) begin
      r.first = ring_slots[ring_front];
      r.last  = ring_slots[(ring_front + ring_count - 1) % DEPTH];
    end
    return r;
  endfunction

  // Send one beat; leaves tvalid high so the next beat can follow at once
  task automatic send_op(logic [FUNC_W-1:0] func, logic [VALUE_W-1:0] value);
    int gap;
    gap = tx_gaps_on ? $urandom_range(12, 0) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W - IN_BITS){1'b0}}, value, func};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(apply_deq_op(func, value));
  endtask

  // Stop sending and wait for every outstanding result
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Handle value with extra weight on all-zeros and all-ones
  function automatic logic [VALUE_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(7, 0);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return $urandom;
  endfunction

  // Random operation: a little noise from no-op codes, p_add percent adds among the rest
  function automatic logic [FUNC_W-1:0] pick_func(int p_add);
    int roll;
    roll = $urandom_range(99, 0);
    if (roll < 8) return (roll < 3) ? OP_NONE
                         : FUNC_W'($urandom_range({FUNC_W{1'b1}}, OP_REM_B + 1));
    if ($urandom_range(99, 0) < p_add)
      return $urandom_range(1, 0) ? OP_ADD_F : OP_ADD_B;
    return $urandom_range(1, 0) ? OP_REM_F : OP_REM_B;
  endfunction

  // Edge cases: empty removes, idle codes, extreme handles, wrap at slot 0
  task automatic test_directed();
    logic [FUNC_W-1:0] f;
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
    send_op(OP_REM_F, '1);
    send_op(OP_REM_B, '0);
    send_op(OP_NONE, '1);
    for (int i = OP_REM_B + 1; i <= {FUNC_W{1'b1}}; i++) begin
      f = FUNC_W'(i);
      send_op(f, $urandom);
    end
    send_op(OP_ADD_F, '0);
    send_op(OP_ADD_B, '1);
    send_op(OP_ADD_F, 32'h8000_0001);
    send_op(OP_REM_B, '0);
    send_op(OP_REM_F, '1);
    send_op(OP_REM_F, '0);
    send_op(OP_REM_F, '0);
    send_op(OP_ADD_B, 32'h5A5A_A5A5);
    send_op(OP_REM_B, '0);
    drain_results();
  endtask

  // Full-rate traffic with no gaps and no stalls
  task automatic test_back_to_back(int n_items);
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    for (int i = 0; i < n_items; i++)
      send_op(pick_func((i / 40) % 2 == 0 ? 80 : 20), pick_value());
    drain_results();
  endtask

  // Segments that lean toward filling or draining, so full and empty recur
  task automatic test_random_walk(int n_items);
    int left;
    int seg;
    int p_add;
    left = n_items;
    while (left > 0) begin
      seg = $urandom_range(60, 20);
      if (seg > left) seg = left;
      case ($urandom_range(2, 0))
        0:       p_add = 85;
        1:       p_add = 50;
        default: p_add = 15;
      endcase
      tx_gaps_on   = ($urandom_range(3, 0) != 0);
      rx_stalls_on = ($urandom_range(3, 0) != 0);
      for (int i = 0; i < seg; i++)
        send_op(pick_func(p_add), pick_value());
      left -= seg;
      // hold off now and then until the block has caught up
      if ($urandom_range(4, 0) == 0) drain_results();
    end
    drain_results();
  endtask

  // Result sink with random back-pressure per beat
  initial begin
    int stall;
    out_tready <= 1'b0;
    @(posedge clk iff rst_n);
    out_tready <= 1'b1;
    forever begin
      do @(posedge clk); while (!(out_tvalid && out_tready));
      stall = rx_stalls_on ? $urandom_range(12, 0) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  task automatic cmp_field(string name, logic [VALUE_W-1:0] exp_v,
                           logic [VALUE_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      error_cnt++;
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    deq_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %h",
                 $time, out_tdata);
        error_cnt++;
      end else begin
        exp_r = pending_results.pop_front();
        cmp_field("removed_item", exp_r.removed, out_tdata[OFS_STATUS-1:0]);
        cmp_field("status", VALUE_W'(exp_r.status),
                  VALUE_W'(out_tdata[OFS_COUNT-1:OFS_STATUS]));
        cmp_field("item_count", VALUE_W'(exp_r.count),
                  VALUE_W'(out_tdata[OFS_FIRST-1:OFS_COUNT]));
        cmp_field("first_item", exp_r.first, out_tdata[OFS_LAST-1:OFS_FIRST]);
        cmp_field("last_item", exp_r.last, out_tdata[OFS_LAST+VALUE_W-1:OFS_LAST]);
      end
    end
  end

  // Watchdog
  initial begin
    #3ms;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    error_cnt    = 0;
    ring_front   = 0;
    ring_count   = 0;
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_back_to_back(150);
    test_random_walk(750);

    repeat (10) @(posedge clk);
    if (error_cnt == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
